// ===== hdl/waypoint_turn_and_distance_planner_unit_macros.svh =====
// assertion macros for the waypoint planner checker
// no dependencies; taken in by the checker file only
`ifndef WAYPOINT_TURN_AND_DISTANCE_PLANNER_UNIT_MACROS_SVH
`define WAYPOINT_TURN_AND_DISTANCE_PLANNER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define WTDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define WTDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wtdp_pkg.sv =====
// shared types, widths, constants and the arctangent table of the waypoint planner
// no dependencies
`timescale 1ns / 1ps

package wtdp_pkg;

  // field widths
  localparam int POS_W  = 24;
  localparam int HDG_W  = 17;
  localparam int AMT_W  = 25;
  localparam int KIND_W = 2;

  // stream packing
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 48;
  localparam int CX_LSB = 0;
  localparam int CY_LSB = CX_LSB + POS_W;
  localparam int CH_LSB = CY_LSB + POS_W;
  localparam int GX_LSB = CH_LSB + HDG_W;
  localparam int GY_LSB = GX_LSB + POS_W;
  localparam int AMT_LSB = 0;
  localparam int PHD_LSB = AMT_LSB + AMT_W;
  localparam int OUT_PAD_W = OUT_TDATA_W - AMT_W - HDG_W;

  // datapath widths
  localparam int DIFF_W = POS_W + 1;
  localparam int MAG_W  = DIFF_W;
  localparam int CRD_W  = MAG_W + 11;
  localparam int ANG_W  = 25;
  localparam int ATAN_W = 22;
  localparam int ATAN_LEN = 24;
  localparam int TURN_W = HDG_W + 2;
  localparam int TMAG_W = 16;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ROOT_W = SQ_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SQRT_STEPS = SQ_W / 2;

  // squares, sum, root steps, rounding, saturation
  localparam int PIPE_LAT = SQRT_STEPS + 4;

  // angles in degrees * 65536
  localparam logic [ANG_W-1:0] DEG90_Q16  = ANG_W'(5898240);
  localparam logic [ANG_W-1:0] DEG180_Q16 = ANG_W'(11796480);
  localparam logic [ANG_W-1:0] DEG360_Q16 = ANG_W'(23592960);
  localparam logic [ANG_W:0]   ROUND_Q16  = (ANG_W + 1)'(128);

  // angles in degrees * 256
  localparam logic [HDG_W:0]          FULL_Q8   = (HDG_W + 1)'(92160);
  localparam logic signed [TURN_W-1:0] TURN_FULL = TURN_W'(92160);
  localparam logic signed [TURN_W-1:0] TURN_HALF = TURN_W'(46080);
  localparam logic [AMT_W-1:0]        TURN_MAX_Q8 = AMT_W'(46080);

  localparam logic [AMT_W-1:0] AMOUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    MOVE_CW   = 2'd0,
    MOVE_CCW  = 2'd1,
    MOVE_FWD  = 2'd2,
    MOVE_STOP = 2'd3
  } move_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TURN,
    PH_FWD,
    PH_STOP
  } phase_e;

  // quadrant and axis information that travels beside the cordic
  typedef struct packed {
    logic             adx_zero;
    logic             ady_zero;
    logic             dx_neg;
    logic             dy_neg;
    logic [HDG_W-1:0] cur_hdg;
  } side_t;

  // planned turn handed to the move sequencer
  typedef struct packed {
    logic              has_turn;
    logic              ccw;
    logic [TMAG_W-1:0] mag;
    logic [HDG_W-1:0]  heading;
  } turn_t;

  // atan(2^-i) in degrees * 65536
  function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/waypoint_turn_and_distance_planner_unit.sv =====
// waypoint planner top level: input stages, heading and distance pipelines, move sequencer
// depends on wtdp_pkg, wtdp_heading, wtdp_dist and wtdp_emit
//
// Input stream s_axis: one transfer carries the current pose and a goal point.
// Output stream m_axis: each waypoint gives an optional turn (clockwise or
// counterclockwise, by its magnitude, with the planned heading), one forward move
// by the rounded euclidean distance and a stop move marked by tlast.
// The first move of a waypoint is presented after its input transfer has passed
// the two input stages, the pipeline and the sequencer state register when the
// output is free; this does not depend on CORDIC_STAGES, as the heading path is
// padded to the length of the root extraction, which resolves one root bit per stage over 25 stages.
// Throughput: a waypoint may be accepted every cycle into the pipeline while
// s_axis_tready is high; the sustained rate is set by the single output channel
// that carries all moves, three per waypoint with a turn and two without.
// Reset clears all valid bits and the sequencer, so the pipeline starts empty.
// When the receiver stalls, the sequencer holds its move and, once the last
// pipeline stage holds a waypoint it cannot take, the whole pipeline freezes
// and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module waypoint_turn_and_distance_planner_unit import wtdp_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // current_x, current_y, current_heading, goal_x, goal_y, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // amount, planned_heading, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // move_kind
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic en;
  logic emit_ready;
  logic v1_q;
  logic v2_q;
  logic [PIPE_LAT-1:0] vp_q;
  logic v_last;

  assign v_last        = vp_q[PIPE_LAT-1];
  assign en            = !v_last || emit_ready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vp_q <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      vp_q <= {vp_q[PIPE_LAT-2:0], v2_q};
    end
  end

  // offsets to the goal
  logic signed [DIFF_W-1:0] dx_q;
  logic signed [DIFF_W-1:0] dy_q;
  logic [HDG_W-1:0]         ch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DIFF_W'($signed(s_axis_tdata[GX_LSB +: POS_W]))
            - DIFF_W'($signed(s_axis_tdata[CX_LSB +: POS_W]));
      dy_q <= DIFF_W'($signed(s_axis_tdata[GY_LSB +: POS_W]))
            - DIFF_W'($signed(s_axis_tdata[CY_LSB +: POS_W]));
      ch_q <= s_axis_tdata[CH_LSB +: HDG_W];
    end
  end

  // magnitudes and quadrant
  logic [MAG_W-1:0] adx_q;
  logic [MAG_W-1:0] ady_q;
  side_t            side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q           <= dx_q[DIFF_W-1] ? MAG_W'(-dx_q) : MAG_W'(dx_q);
      ady_q           <= dy_q[DIFF_W-1] ? MAG_W'(-dy_q) : MAG_W'(dy_q);
      side_q.adx_zero <= (dx_q == '0);
      side_q.ady_zero <= (dy_q == '0);
      side_q.dx_neg   <= dx_q[DIFF_W-1];
      side_q.dy_neg   <= dy_q[DIFF_W-1];
      side_q.cur_hdg  <= ch_q;
    end
  end

  turn_t            turn;
  logic [AMT_W-1:0] dist_amt;

  wtdp_heading #(
    .STAGES(CORDIC_STAGES)
  ) u_heading (
    .clk_i  (clk_i),
    .en_i   (en),
    .adx_i  (adx_q),
    .ady_i  (ady_q),
    .side_i (side_q),
    .turn_o (turn)
  );

  wtdp_dist u_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .adx_i  (adx_q),
    .ady_i  (ady_q),
    .dist_o (dist_amt)
  );

  move_kind_e       kind;
  logic [AMT_W-1:0] amount;
  logic [HDG_W-1:0] heading;

  wtdp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (v_last),
    .turn_i       (turn),
    .dist_i       (dist_amt),
    .ready_o      (emit_ready),
    .valid_o      (m_axis_tvalid),
    .tready_i     (m_axis_tready),
    .kind_o       (kind),
    .amount_o     (amount),
    .heading_o    (heading),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, heading, amount};
  assign m_axis_tuser = kind;

endmodule

// ===== hdl/wtdp_cordic.sv =====
// pipelined vectoring cordic, one rotation per register stage
// depends on wtdp_pkg
`timescale 1ns / 1ps

module wtdp_cordic import wtdp_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [MAG_W-1:0]        ax_i,
  input  logic [MAG_W-1:0]        ay_i,
  output logic signed [ANG_W-1:0] z_o
);

  // x is not needed by the last two stages, y not by the last one
  logic signed [CRD_W-1:0] x_q [STAGES-2];
  logic signed [CRD_W-1:0] y_q [STAGES-1];
  logic signed [ANG_W-1:0] z_q [STAGES];
  logic signed [CRD_W-1:0] x0;
  logic signed [CRD_W-1:0] y0;

  assign x0 = signed'({{(CRD_W - MAG_W - 8){1'b0}}, ax_i, 8'h00});
  assign y0 = signed'({{(CRD_W - MAG_W - 8){1'b0}}, ay_i, 8'h00});

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CRD_W-1:0] yi;
    logic signed [ANG_W-1:0] zi;
    logic signed [ANG_W-1:0] ang;
    logic                    pos;

    if (i == 0) begin : g_head
      assign yi = y0;
      assign zi = '0;
    end else begin : g_tail
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end

    assign pos = !yi[CRD_W-1] && (yi != '0);
    assign ang = ANG_W'(atan_q16(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i] <= pos ? zi + ang : zi - ang;
      end
    end

    if (i < STAGES - 1) begin : g_y
      logic signed [CRD_W-1:0] xi;
      if (i == 0) begin : g_x0
        assign xi = x0;
      end else begin : g_xn
        assign xi = x_q[i-1];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[i] <= pos ? yi - (xi >>> i) : yi + (xi >>> i);
        end
      end

      if (i < STAGES - 2) begin : g_x
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            x_q[i] <= pos ? xi + (yi >>> i) : xi - (yi >>> i);
          end
        end
      end
    end
  end

  assign z_o = z_q[STAGES-1];

endmodule

// ===== hdl/wtdp_heading.sv =====
// target heading and shortest turn: cordic, quadrant mapping, rounding, turn wrap
// depends on wtdp_pkg and wtdp_cordic
`timescale 1ns / 1ps

module wtdp_heading import wtdp_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] adx_i,
  input  logic [MAG_W-1:0] ady_i,
  input  side_t            side_i,
  output turn_t            turn_o
);

  // delay that lines the turn up with the distance path
  localparam int PAD = PIPE_LAT - 3 - STAGES;

  logic signed [ANG_W-1:0] z;
  side_t                   side_q [STAGES];

  // angle measured from +y, so |dy| is the cordic x input
  wtdp_cordic #(
    .STAGES(STAGES)
  ) u_cordic (
    .clk_i (clk_i),
    .en_i  (en_i),
    .ax_i  (ady_i),
    .ay_i  (adx_i),
    .z_o   (z)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // quadrant mapping
  side_t            sd;
  logic [ANG_W-1:0] a;
  logic [ANG_W-1:0] h_d;
  logic [ANG_W-1:0] h_q;
  logic [HDG_W-1:0] ch_a_q;

  assign sd = side_q[STAGES-1];

  always_comb begin
    if (sd.adx_zero) begin
      a = '0;
    end else if (sd.ady_zero) begin
      a = DEG90_Q16;
    end else if (z[ANG_W-1]) begin
      a = '0;
    end else if ($unsigned(z) > DEG90_Q16) begin
      a = DEG90_Q16;
    end else begin
      a = $unsigned(z);
    end

    if (!sd.dx_neg && !sd.dy_neg) begin
      h_d = a;
    end else if (!sd.dx_neg) begin
      h_d = DEG180_Q16 - a;
    end else if (sd.dy_neg) begin
      h_d = DEG180_Q16 + a;
    end else begin
      h_d = DEG360_Q16 - a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q    <= h_d;
      ch_a_q <= sd.cur_hdg;
    end
  end

  // round to degrees * 256 and wrap a full circle to zero
  logic [ANG_W:0]   h_rnd;
  logic [HDG_W:0]   h8_full;
  logic [HDG_W-1:0] h8_d;
  logic [HDG_W-1:0] h8_q;
  logic [HDG_W-1:0] ch_b_q;

  assign h_rnd   = {1'b0, h_q} + ROUND_Q16;
  assign h8_full = h_rnd[HDG_W+8:8];

  always_comb begin
    if (h8_full >= FULL_Q8) begin
      h8_d = HDG_W'(h8_full - FULL_Q8);
    end else begin
      h8_d = h8_full[HDG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h8_q   <= h8_d;
      ch_b_q <= ch_a_q;
    end
  end

  // raw turn, lifted above minus half a circle
  logic signed [TURN_W-1:0] t_raw;
  logic signed [TURN_W-1:0] t1_q;
  logic [HDG_W-1:0]         h8_c_q;

  assign t_raw = signed'({2'b00, h8_q}) - signed'({2'b00, ch_b_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= (t_raw < -TURN_HALF) ? t_raw + TURN_FULL : t_raw;
      h8_c_q <= h8_q;
    end
  end

  // bring down past plus half a circle; a turn of exactly half a circle keeps its raw sign
  logic signed [TURN_W-1:0] t2;
  logic signed [TURN_W-1:0] t_abs;
  turn_t                    turn_d;
  turn_t                    pad_q [PAD];

  assign t2    = (t1_q > TURN_HALF) ? t1_q - TURN_FULL : t1_q;
  assign t_abs = t2[TURN_W-1] ? -t2 : t2;

  always_comb begin
    turn_d.has_turn = (t2 != '0);
    turn_d.ccw      = t2[TURN_W-1];
    turn_d.mag      = t_abs[TMAG_W-1:0];
    turn_d.heading  = h8_c_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pad_q[0] <= turn_d;
      for (int k = 1; k < PAD; k++) begin
        pad_q[k] <= pad_q[k-1];
      end
    end
  end

  assign turn_o = pad_q[PAD-1];

endmodule

// ===== hdl/wtdp_dist.sv =====
// euclidean distance: squares, sum, one root bit per stage, round to nearest, saturate
// depends on wtdp_pkg
`timescale 1ns / 1ps

module wtdp_dist import wtdp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] adx_i,
  input  logic [MAG_W-1:0] ady_i,
  output logic [AMT_W-1:0] dist_o
);

  logic [SQ_W-1:0] sqx_q;
  logic [SQ_W-1:0] sqy_q;
  logic [SQ_W-1:0] n_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= adx_i * adx_i;
      sqy_q <= ady_i * ady_i;
      n_q   <= sqx_q + sqy_q;
    end
  end

  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  logic [SQ_W-1:0]   nd_q   [SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [SQ_W-1:0]   nk;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_head
      assign nk      = n_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_tail
      assign nk      = nd_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next pair of radicand bits and try (root << 2) + 1
    assign rem_sh = {rem_in[REM_W-3:0], nk[SQ_W-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nd_q[k] <= nk;
        end
      end
    end
  end

  logic [ROOT_W:0]   rnd_q;
  logic [AMT_W-1:0]  dist_q;
  logic [ROOT_W-1:0] root_f;
  logic [REM_W-1:0]  rem_f;
  logic              up;

  assign root_f = root_q[SQRT_STEPS-1];
  assign rem_f  = rem_q[SQRT_STEPS-1];
  // remainder above the root means the true root is past the half-way point
  assign up     = (rem_f > REM_W'(root_f));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q  <= (ROOT_W + 1)'(root_f) + (ROOT_W + 1)'(up);
      dist_q <= rnd_q[ROOT_W] ? AMOUNT_MAX : rnd_q[AMT_W-1:0];
    end
  end

  assign dist_o = dist_q;

endmodule

// ===== hdl/wtdp_emit.sv =====
// move sequencer: turns one plan into turn, forward and stop transfers
// depends on wtdp_pkg
`timescale 1ns / 1ps

module wtdp_emit import wtdp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              plan_valid_i,
  input  turn_t             turn_i,
  input  logic [AMT_W-1:0]  dist_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              tready_i,
  output move_kind_e        kind_o,
  output logic [AMT_W-1:0]  amount_o,
  output logic [HDG_W-1:0]  heading_o,
  output logic              last_o
);

  phase_e           state_q;
  phase_e           state_d;
  turn_t            turn_q;
  logic [AMT_W-1:0] dist_q;
  logic             load;

  // a new plan is taken when idle or while the stop move of the previous one goes out
  assign ready_o = (state_q == PH_IDLE) || ((state_q == PH_STOP) && tready_i);
  assign load    = plan_valid_i && ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      PH_IDLE: begin
        if (plan_valid_i) begin
          state_d = turn_i.has_turn ? PH_TURN : PH_FWD;
        end
      end
      PH_TURN: begin
        if (tready_i) begin
          state_d = PH_FWD;
        end
      end
      PH_FWD: begin
        if (tready_i) begin
          state_d = PH_STOP;
        end
      end
      PH_STOP: begin
        if (tready_i) begin
          if (plan_valid_i) begin
            state_d = turn_i.has_turn ? PH_TURN : PH_FWD;
          end else begin
            state_d = PH_IDLE;
          end
        end
      end
      default: state_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      turn_q <= turn_i;
      dist_q <= dist_i;
    end
  end

  always_comb begin
    valid_o   = 1'b0;
    kind_o    = MOVE_STOP;
    amount_o  = '0;
    heading_o = '0;
    last_o    = 1'b0;
    case (state_q)
      PH_IDLE: begin
        valid_o = 1'b0;
      end
      PH_TURN: begin
        valid_o   = 1'b1;
        kind_o    = turn_q.ccw ? MOVE_CCW : MOVE_CW;
        amount_o  = AMT_W'(turn_q.mag);
        heading_o = turn_q.heading;
      end
      PH_FWD: begin
        valid_o  = 1'b1;
        kind_o   = MOVE_FWD;
        amount_o = dist_q;
      end
      PH_STOP: begin
        valid_o = 1'b1;
        kind_o  = MOVE_STOP;
        last_o  = 1'b1;
      end
      default: valid_o = 1'b0;
    endcase
  end

endmodule

// ===== hdl/wtdp_checker.sv =====
// port-level checks of the waypoint planner and the bind that attaches them
// depends on wtdp_pkg and the planner macro header
`timescale 1ns / 1ps
`include "waypoint_turn_and_distance_planner_unit_macros.svh"

module wtdp_checker import wtdp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]      m_axis_tuser,
  input logic                   m_axis_tlast
);

  // a stalled move stays on the bus unchanged
  `WTDP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled move changed")

  // only the stop move ends a run
  `WTDP_ASSERT_IMP(a_stop_last, clk_i, rst_ni, m_axis_tvalid, (m_axis_tuser == MOVE_STOP) == m_axis_tlast, "tlast does not match stop move")

  // a forward transfer is always followed by its stop move
  `WTDP_ASSERT_NXT(a_fwd_stop, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && (m_axis_tuser == MOVE_FWD), m_axis_tvalid && (m_axis_tuser == MOVE_STOP), "forward move not followed by stop")

  // turns are nonzero and never beyond half a circle
  `WTDP_ASSERT_IMP(a_turn_bound, clk_i, rst_ni, m_axis_tvalid && ((m_axis_tuser == MOVE_CW) || (m_axis_tuser == MOVE_CCW)), (m_axis_tdata[AMT_W-1:0] != '0) && (m_axis_tdata[AMT_W-1:0] <= TURN_MAX_Q8), "turn amount out of range")

endmodule

bind waypoint_turn_and_distance_planner_unit wtdp_checker u_checker (.*);
